FILE: rtl/lav_pkg.sv
`default_nettype none
package lav_pkg;

   localparam int DATA_W = 32;
   localparam int VEC_W  = 64;
   localparam int MAG_W  = 31;
   localparam int SQRT_W = 32;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } norm_side_type;

endpackage
`default_nettype wire

FILE: rtl/lav_req_if.sv
`default_nettype none
interface lav_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] tgt_x;
   logic signed [31:0] tgt_y;
   logic signed [31:0] tgt_z;
   logic signed [31:0] wup_x;
   logic signed [31:0] wup_y;
   logic signed [31:0] wup_z;

   modport source (output valid, pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z,
                   wup_x, wup_y, wup_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z,
                 wup_x, wup_y, wup_z, output ready);
endinterface
`default_nettype wire

FILE: rtl/lav_rsp_if.sv
`default_nettype none
interface lav_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] right_x;
   logic signed [31:0] right_y;
   logic signed [31:0] right_z;
   logic signed [31:0] upv_x;
   logic signed [31:0] upv_y;
   logic signed [31:0] upv_z;
   logic signed [31:0] back_x;
   logic signed [31:0] back_y;
   logic signed [31:0] back_z;
   logic signed [31:0] shift_r;
   logic signed [31:0] shift_u;
   logic signed [31:0] shift_b;

   modport source (output valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
                   back_x, back_y, back_z, shift_r, shift_u, shift_b, input ready);
   modport sink (input valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
                 back_x, back_y, back_z, shift_r, shift_u, shift_b, output ready);
endinterface
`default_nettype wire

FILE: rtl/lav_delay.sv
`default_nettype none
module lav_delay import lav_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] data_in,
   output logic      [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= data_in;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign data_out = data_ff[DEPTH-1];

endmodule
`default_nettype wire

FILE: rtl/lav_cross.sv
`default_nettype none
module lav_cross import lav_pkg::*; #(
   parameter int AW = 18,
   parameter int BW = 18
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [2:0][AW-1:0]     a_in,
   input  wire logic [2:0][BW-1:0]     b_in,
   output logic      [2:0][AW+BW:0]    cross_out
);

   localparam int PW = AW + BW;

   logic signed [PW-1:0] prod_ff [6];
   logic signed [PW-1:0] prod_in [6];
   logic [2:0][PW:0]     diff_ff;
   logic [2:0][PW:0]     diff_in;

   always_comb begin
      prod_in[0] = $signed(a_in[1]) * $signed(b_in[2]);
      prod_in[1] = $signed(a_in[2]) * $signed(b_in[1]);
      prod_in[2] = $signed(a_in[2]) * $signed(b_in[0]);
      prod_in[3] = $signed(a_in[0]) * $signed(b_in[2]);
      prod_in[4] = $signed(a_in[0]) * $signed(b_in[1]);
      prod_in[5] = $signed(a_in[1]) * $signed(b_in[0]);
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = (PW+1)'(prod_ff[2*i]) - (PW+1)'(prod_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         diff_ff <= diff_in;
      end
   end

   assign cross_out = diff_ff;

endmodule
`default_nettype wire

FILE: rtl/lav_norm.sv
`default_nettype none
module lav_norm import lav_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [2:0][VEC_W-1:0]       vec_in,
   output logic      [2:0][FRAC_BITS+1:0]   unit_out
);

   localparam int QW = FRAC_BITS + 1;
   localparam int UW = FRAC_BITS + 2;
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int PW = $clog2(VEC_W);
   localparam int RW = SQRT_W + 2;
   localparam int DW = SQRT_W + 1;

   logic [2:0][VEC_W-1:0]   mag_a_ff, mag_a_in;
   logic [VEC_W-1:0]        orr_a_ff, orr_a_in;
   norm_side_type           side_a_ff, side_a_in;
   logic [2:0][VEC_W-1:0]   mag_b_ff;
   logic [PW-1:0]           msb_b_ff, msb_b_in;
   norm_side_type           side_b_ff, side_b_in;
   logic [2:0][MAG_W-1:0]   m_c_ff, m_c_in;
   norm_side_type           side_c_ff;
   logic [2:0][2*MAG_W-1:0] sq_d_ff, sq_d_in;
   logic [2:0][MAG_W-1:0]   m_d_ff;
   norm_side_type           side_d_ff;
   logic [VEC_W-1:0]        sum_e_ff, sum_e_in;
   logic [2:0][MAG_W-1:0]   m_e_ff;
   norm_side_type           side_e_ff;

   logic [RW-1:0]           sq_rem_ff  [SQRT_W];
   logic [SQRT_W-1:0]       sq_root_ff [SQRT_W];
   logic [VEC_W-1:0]        sq_val_ff  [SQRT_W];
   logic [2:0][MAG_W-1:0]   sq_m_ff    [SQRT_W];
   norm_side_type           sq_side_ff [SQRT_W];

   logic [2:0][DW-1:0]      dv_rem_ff  [DIV_STEPS];
   logic [2:0][QW-1:0]      dv_q_ff    [DIV_STEPS];
   logic [SQRT_W-1:0]       dv_r_ff    [DIV_STEPS];
   norm_side_type           dv_side_ff [DIV_STEPS];

   logic [2:0][UW-1:0]      unit_ff, unit_in;

   always_comb begin
      orr_a_in = '0;
      side_a_in = '0;
      for (int i = 0; i < 3; i++) begin
         side_a_in.neg[i] = vec_in[i][VEC_W-1];
         mag_a_in[i] = vec_in[i][VEC_W-1] ? (~vec_in[i] + 1'b1) : vec_in[i];
         orr_a_in = orr_a_in | mag_a_in[i];
      end
   end

   always_comb begin
      msb_b_in = '0;
      for (int b = 0; b < VEC_W; b++) begin
         if (orr_a_ff[b]) begin
            msb_b_in = PW'(b);
         end
      end
      side_b_in = side_a_ff;
      side_b_in.zero = (orr_a_ff == '0);
   end

   always_comb begin
      logic [VEC_W-1:0] sh;
      sh = '0;
      for (int i = 0; i < 3; i++) begin
         if (msb_b_ff > PW'(MAG_W-1)) begin
            sh = mag_b_ff[i] >> (msb_b_ff - PW'(MAG_W-1));
         end else begin
            sh = mag_b_ff[i] << (PW'(MAG_W-1) - msb_b_ff);
         end
         m_c_in[i] = sh[MAG_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_d_in[i] = (2*MAG_W)'(m_c_ff[i]) * (2*MAG_W)'(m_c_ff[i]);
      end
      sum_e_in = VEC_W'(sq_d_ff[0]) + VEC_W'(sq_d_ff[1]) + VEC_W'(sq_d_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff  <= mag_a_in;
         orr_a_ff  <= orr_a_in;
         side_a_ff <= side_a_in;
         mag_b_ff  <= mag_a_ff;
         msb_b_ff  <= msb_b_in;
         side_b_ff <= side_b_in;
         m_c_ff    <= m_c_in;
         side_c_ff <= side_b_ff;
         sq_d_ff   <= sq_d_in;
         m_d_ff    <= m_c_ff;
         side_d_ff <= side_c_ff;
         sum_e_ff  <= sum_e_in;
         m_e_ff    <= m_d_ff;
         side_e_ff <= side_d_ff;
      end
   end

   for (genvar k = 0; k < SQRT_W; k++) begin : g_sqrt
      localparam int J = SQRT_W - 1 - k;
      logic [RW-1:0]         prev_rem;
      logic [SQRT_W-1:0]     prev_root;
      logic [VEC_W-1:0]      prev_val;
      logic [2:0][MAG_W-1:0] prev_m;
      norm_side_type         prev_side;
      logic [RW+1:0]         cur;
      logic [RW+1:0]         trial;

      if (k == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_val  = sum_e_ff;
         assign prev_m    = m_e_ff;
         assign prev_side = side_e_ff;
      end else begin : g_next
         assign prev_rem  = sq_rem_ff[k-1];
         assign prev_root = sq_root_ff[k-1];
         assign prev_val  = sq_val_ff[k-1];
         assign prev_m    = sq_m_ff[k-1];
         assign prev_side = sq_side_ff[k-1];
      end

      assign cur   = {prev_rem, prev_val[2*J+1:2*J]};
      assign trial = (RW+2)'({prev_root, 2'b01});

      always_ff @(posedge clock) begin
         if (en) begin
            if (cur >= trial) begin
               sq_rem_ff[k]  <= RW'(cur - trial);
               sq_root_ff[k] <= {prev_root[SQRT_W-2:0], 1'b1};
            end else begin
               sq_rem_ff[k]  <= cur[RW-1:0];
               sq_root_ff[k] <= {prev_root[SQRT_W-2:0], 1'b0};
            end
            sq_val_ff[k]  <= prev_val;
            sq_m_ff[k]    <= prev_m;
            sq_side_ff[k] <= prev_side;
         end
      end
   end

   for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
      logic [2:0][DW-1:0] prev_rem;
      logic [2:0][QW-1:0] prev_q;
      logic [SQRT_W-1:0]  prev_r;
      norm_side_type      prev_side;
      logic [2:0][DW-1:0] cand;
      logic [2:0][DW-1:0] rem_in;
      logic [2:0][QW-1:0] q_in;

      if (d == 0) begin : g_first
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign prev_rem[i] = DW'(sq_m_ff[SQRT_W-1][i]);
            assign cand[i]     = prev_rem[i];
         end
         assign prev_q    = '0;
         assign prev_r    = sq_root_ff[SQRT_W-1];
         assign prev_side = sq_side_ff[SQRT_W-1];
      end else begin : g_next
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign cand[i] = {prev_rem[i][DW-2:0], 1'b0};
         end
         assign prev_rem  = dv_rem_ff[d-1];
         assign prev_q    = dv_q_ff[d-1];
         assign prev_r    = dv_r_ff[d-1];
         assign prev_side = dv_side_ff[d-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (cand[i] >= DW'(prev_r)) begin
               rem_in[i] = cand[i] - DW'(prev_r);
               q_in[i]   = {prev_q[i][QW-2:0], 1'b1};
            end else begin
               rem_in[i] = cand[i];
               q_in[i]   = {prev_q[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[d]  <= rem_in;
            dv_q_ff[d]    <= q_in;
            dv_r_ff[d]    <= prev_r;
            dv_side_ff[d] <= prev_side;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_side_ff[DIV_STEPS-1].zero) begin
            unit_in[i] = '0;
         end else if (dv_side_ff[DIV_STEPS-1].neg[i]) begin
            unit_in[i] = UW'(0) - UW'(dv_q_ff[DIV_STEPS-1][i]);
         end else begin
            unit_in[i] = UW'(dv_q_ff[DIV_STEPS-1][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_ff <= unit_in;
      end
   end

   assign unit_out = unit_ff;

endmodule
`default_nettype wire

FILE: rtl/look_at_view_matrix.sv
// Channel    Dir  Transaction
// ---------  ---  ----------------------------------------------------------
// req_chan   in   pos, tgt, wup vectors, signed Q.FRAC_BITS, 32 bits each
// rsp_chan   out  right, upv, back axes and shift_r/u/b, 32 bits each
//
// One transaction per cycle unless the output stalls. Each normalize is a
// 32-step square root plus a FRAC_BITS+1 step divider, one step per stage.
// Reset clears only the valid bits. When the output register holds a result
// that is not taken, the whole pipeline holds.
`default_nettype none
module look_at_view_matrix import lav_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lav_req_if.sink    req_chan,
   lav_rsp_if.source  rsp_chan
);

   localparam int UW   = FRAC_BITS + 2;
   localparam int CW   = 2*UW + 1;
   localparam int UPW  = FRAC_BITS + 3;
   localparam int PRW  = UPW + DATA_W;
   localparam int SW   = PRW + 2;
   localparam int NL   = FRAC_BITS + SQRT_W + 7;
   localparam int TOT  = 2*NL + 9;

   logic                    en;
   logic [TOT-1:0]          vld_ff;

   logic [2:0][DATA_W-1:0]  pos_ff;
   logic [2:0][VEC_W-1:0]   diff_ff;
   logic [2:0][VEC_W-1:0]   wup_ff;

   logic [2:0][UW-1:0]      back_n;
   logic [2:0][UW-1:0]      nup_n;
   logic [2:0][UW-1:0]      right_n;
   logic [2:0][CW-1:0]      cr_c;
   logic [2:0][VEC_W-1:0]   cr_ext;
   logic [2:0][UW-1:0]      back_c;
   logic [2:0][CW-1:0]      upw_c;
   logic [2:0][UW-1:0]      back_u;
   logic [2:0][UW-1:0]      right_u;
   logic [2:0][DATA_W-1:0]  pos_u;

   logic [2:0][UPW-1:0]     upv_ff, upv_in;
   logic [2:0][UW-1:0]      right_v_ff, back_v_ff;
   logic [2:0][DATA_W-1:0]  pos_v_ff;

   logic [2:0][PRW-1:0]     pr_r_ff, pr_u_ff, pr_b_ff;
   logic [2:0][PRW-1:0]     pr_r_in, pr_u_in, pr_b_in;
   logic [2:0][UW-1:0]      right_m_ff, back_m_ff;
   logic [2:0][UPW-1:0]     upv_m_ff;

   logic [2:0][SW-1:0]      dot_ff, dot_in;
   logic [2:0][UW-1:0]      right_s_ff, back_s_ff;
   logic [2:0][UPW-1:0]     upv_s_ff;

   logic [2:0][DATA_W-1:0]  right_o_ff, upv_o_ff, back_o_ff, shift_o_ff;
   logic [2:0][DATA_W-1:0]  right_o_in, upv_o_in, back_o_in, shift_o_in;

   function automatic logic [VEC_W-1:0] sub_ext(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
      logic [DATA_W:0] d;
      d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      return VEC_W'($signed(d));
   endfunction

   function automatic logic [VEC_W-1:0] round_frac(input logic [VEC_W-1:0] x);
      logic [VEC_W-1:0] m;
      m = x[VEC_W-1] ? (~x + 1'b1) : x;
      m = (m + (VEC_W'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
      return x[VEC_W-1] ? (~m + 1'b1) : m;
   endfunction

   function automatic logic [DATA_W-1:0] neg_sat(input logic [VEC_W-1:0] x);
      logic signed [VEC_W-1:0] d;
      d = -$signed(round_frac(x));
      if (d > $signed(VEC_W'(64'sd2147483647))) begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end else if (d < $signed(VEC_W'(-64'sd2147483648))) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end
      return d[DATA_W-1:0];
   endfunction

   assign en = !vld_ff[TOT-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOT-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0]  <= req_chan.pos_x;
         pos_ff[1]  <= req_chan.pos_y;
         pos_ff[2]  <= req_chan.pos_z;
         diff_ff[0] <= sub_ext(req_chan.pos_x, req_chan.tgt_x);
         diff_ff[1] <= sub_ext(req_chan.pos_y, req_chan.tgt_y);
         diff_ff[2] <= sub_ext(req_chan.pos_z, req_chan.tgt_z);
         wup_ff[0]  <= VEC_W'(req_chan.wup_x);
         wup_ff[1]  <= VEC_W'(req_chan.wup_y);
         wup_ff[2]  <= VEC_W'(req_chan.wup_z);
      end
   end

   lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_back (
      .clock(clock), .en(en), .vec_in(diff_ff), .unit_out(back_n));

   lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_wup (
      .clock(clock), .en(en), .vec_in(wup_ff), .unit_out(nup_n));

   lav_cross #(.AW(UW), .BW(UW)) u_cross_right (
      .clock(clock), .en(en), .a_in(nup_n), .b_in(back_n), .cross_out(cr_c));

   for (genvar i = 0; i < 3; i++) begin : g_cr_ext
      assign cr_ext[i] = VEC_W'($signed(cr_c[i]));
   end

   lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_right (
      .clock(clock), .en(en), .vec_in(cr_ext), .unit_out(right_n));

   lav_delay #(.WIDTH(3*UW), .DEPTH(NL+2)) u_dly_back_c (
      .clock(clock), .en(en), .data_in(back_n), .data_out(back_c));

   lav_cross #(.AW(UW), .BW(UW)) u_cross_up (
      .clock(clock), .en(en), .a_in(back_c), .b_in(right_n), .cross_out(upw_c));

   lav_delay #(.WIDTH(3*UW), .DEPTH(2)) u_dly_back_u (
      .clock(clock), .en(en), .data_in(back_c), .data_out(back_u));

   lav_delay #(.WIDTH(3*UW), .DEPTH(2)) u_dly_right_u (
      .clock(clock), .en(en), .data_in(right_n), .data_out(right_u));

   lav_delay #(.WIDTH(3*DATA_W), .DEPTH(2*NL+4)) u_dly_pos (
      .clock(clock), .en(en), .data_in(pos_ff), .data_out(pos_u));

   always_comb begin
      logic [VEC_W-1:0] r;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         r = round_frac(VEC_W'($signed(upw_c[i])));
         upv_in[i] = r[UPW-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pr_r_in[i] = PRW'($signed(right_v_ff[i]) * $signed(pos_v_ff[i]));
         pr_u_in[i] = PRW'($signed(upv_ff[i]) * $signed(pos_v_ff[i]));
         pr_b_in[i] = PRW'($signed(back_v_ff[i]) * $signed(pos_v_ff[i]));
      end
      dot_in[0] = SW'($signed(pr_r_ff[0])) + SW'($signed(pr_r_ff[1]))
                + SW'($signed(pr_r_ff[2]));
      dot_in[1] = SW'($signed(pr_u_ff[0])) + SW'($signed(pr_u_ff[1]))
                + SW'($signed(pr_u_ff[2]));
      dot_in[2] = SW'($signed(pr_b_ff[0])) + SW'($signed(pr_b_ff[1]))
                + SW'($signed(pr_b_ff[2]));
      for (int i = 0; i < 3; i++) begin
         right_o_in[i] = DATA_W'($signed(right_s_ff[i]));
         upv_o_in[i]   = DATA_W'($signed(upv_s_ff[i]));
         back_o_in[i]  = DATA_W'($signed(back_s_ff[i]));
         shift_o_in[i] = neg_sat(VEC_W'($signed(dot_ff[i])));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         upv_ff     <= upv_in;
         right_v_ff <= right_u;
         back_v_ff  <= back_u;
         pos_v_ff   <= pos_u;
         pr_r_ff    <= pr_r_in;
         pr_u_ff    <= pr_u_in;
         pr_b_ff    <= pr_b_in;
         right_m_ff <= right_v_ff;
         upv_m_ff   <= upv_ff;
         back_m_ff  <= back_v_ff;
         dot_ff     <= dot_in;
         right_s_ff <= right_m_ff;
         upv_s_ff   <= upv_m_ff;
         back_s_ff  <= back_m_ff;
         right_o_ff <= right_o_in;
         upv_o_ff   <= upv_o_in;
         back_o_ff  <= back_o_in;
         shift_o_ff <= shift_o_in;
      end
   end

   assign rsp_chan.valid   = vld_ff[TOT-1];
   assign rsp_chan.right_x = right_o_ff[0];
   assign rsp_chan.right_y = right_o_ff[1];
   assign rsp_chan.right_z = right_o_ff[2];
   assign rsp_chan.upv_x   = upv_o_ff[0];
   assign rsp_chan.upv_y   = upv_o_ff[1];
   assign rsp_chan.upv_z   = upv_o_ff[2];
   assign rsp_chan.back_x  = back_o_ff[0];
   assign rsp_chan.back_y  = back_o_ff[1];
   assign rsp_chan.back_z  = back_o_ff[2];
   assign rsp_chan.shift_r = shift_o_ff[0];
   assign rsp_chan.shift_u = shift_o_ff[1];
   assign rsp_chan.shift_b = shift_o_ff[2];

endmodule
`default_nettype wire
